// ----- rtl/wvpd_pkg.sv -----
// Shared types and constants for the WAL v1 payload decoder.
// Used by the decoder core, the result queue and the top level. No dependencies.
`default_nettype none

package wvpd_pkg;

    // Leading marker byte of a version 1 payload.
    localparam logic [7:0] MARKER_V1 = 8'hA1;

    // Flags byte bits, and the meta mask bits that are honored.
    localparam int unsigned FLAG_BEFORE_BIT = 0;
    localparam int unsigned FLAG_AFTER_BIT  = 1;
    localparam int unsigned FLAG_META_BIT   = 7;
    localparam logic [7:0]  META_BITS       = 8'h7F;

    // Result tags.
    localparam logic [4:0] KIND_NAME_LEN  = 5'd0;
    localparam logic [4:0] KIND_NAME_BYTE = 5'd1;
    localparam logic [4:0] KIND_OP_SEQ    = 5'd2;
    localparam logic [4:0] KIND_BEF_ID    = 5'd3;
    localparam logic [4:0] KIND_BEF_LEN   = 5'd4;
    localparam logic [4:0] KIND_BEF_BYTE  = 5'd5;
    localparam logic [4:0] KIND_AFT_ID    = 5'd6;
    localparam logic [4:0] KIND_AFT_LEN   = 5'd7;
    localparam logic [4:0] KIND_AFT_BYTE  = 5'd8;
    localparam logic [4:0] KIND_META_BASE = 5'd9;
    localparam logic [4:0] KIND_END       = 5'd16;

    // End status codes.
    localparam logic [3:0] ST_OK            = 4'd0;
    localparam logic [3:0] ST_BAD_MARKER    = 4'd1;
    localparam logic [3:0] ST_NAME_LEN_MISS = 4'd2;
    localparam logic [3:0] ST_NAME_TRUNC    = 4'd3;
    localparam logic [3:0] ST_FLAGS_MISS    = 4'd4;
    localparam logic [3:0] ST_U64_TRUNC     = 4'd5;
    localparam logic [3:0] ST_ROW_ID_MISS   = 4'd6;
    localparam logic [3:0] ST_ROW_LEN_MISS  = 4'd7;
    localparam logic [3:0] ST_ROW_TRUNC     = 4'd8;
    localparam logic [3:0] ST_MASK_MISS     = 4'd9;

    // Default depth of the result queue; must be a power of two, at least 2.
    localparam int unsigned FIFO_DEPTH_DEF = 4;

    // One result item.
    typedef struct packed {
        logic [4:0]  kind;
        logic [63:0] value;
        logic [3:0]  status;
        logic        last;
    } t_result;

endpackage

`default_nettype wire

// ----- rtl/wal_v1_payload_decoder_top.sv -----
// Top level of the WAL v1 payload decoder: input register, parse core, result queue.
// Depends on wvpd_pkg, wvpd_decode and wvpd_fifo.
//
//   Channel | Direction | Handshake          | Payload
//   --------+-----------+--------------------+-------------------------------------------
//   input   | in        | i_valid / o_stall  | i_in_byte, i_in_last
//   result  | out       | o_valid / i_stall  | o_field_kind, o_field_value, o_status,
//           |           |                    | o_out_last
//
// One byte per cycle is accepted while o_stall is low. A byte waits in the input register
// until the queue has room for two results; it is then parsed and its results are written
// into the queue. Each byte yields zero, one or two results; the output side
// moves one result per transfer, so a stream of bytes that each yield two results runs at
// the output rate. The input stalls while a held byte waits for room for two results.
// Reset is synchronous and leaves the parser waiting for a marker byte.
`default_nettype none

module wal_v1_payload_decoder_top
    import wvpd_pkg::*;
#(
    parameter int unsigned P_FIFO_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_field_kind,
    output logic [63:0]      o_field_value,
    output logic [3:0]       o_status,
    output logic             o_out_last
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;
    logic        room2;
    logic        step;
    logic [1:0]  res_cnt;
    logic [1:0]  push_cnt;
    t_result     res0, res1, q_data;

    // Input register; it empties whenever the queue has room for two results.
    assign step    = r_in_valid && room2;
    assign o_stall = r_in_valid && !room2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (!o_stall) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_in_byte <= i_in_byte;
            r_in_last <= i_in_last;
        end
    end

    // Parse core.
    wvpd_decode u_decode (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (step),
        .i_in_byte (r_in_byte),
        .i_in_last (r_in_last),
        .o_res0    (res0),
        .o_res1    (res1),
        .o_res_cnt (res_cnt)
    );

    assign push_cnt = step ? res_cnt : 2'd0;

    // Result queue.
    wvpd_fifo #(
        .P_DEPTH (P_FIFO_DEPTH)
    ) u_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (push_cnt),
        .i_push0    (res0),
        .i_push1    (res1),
        .o_room2    (room2),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_data     (q_data)
    );

    assign o_field_kind  = q_data.kind;
    assign o_field_value = q_data.value;
    assign o_status      = q_data.status;
    assign o_out_last    = q_data.last;

endmodule

`default_nettype wire

// ----- rtl/wvpd_decode.sv -----
// Byte-wise parse state machine for the WAL v1 payload decoder.
// Produces up to two results per byte (a field and an end result). Depends on wvpd_pkg.
`default_nettype none

module wvpd_decode
    import wvpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_step,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    output t_result          o_res0,
    output t_result          o_res1,
    output logic [1:0]       o_res_cnt
);

    typedef enum logic [3:0] {
        PH_MARK, PH_NLEN, PH_NAME, PH_FLAGS, PH_OPSEQ,
        PH_BID, PH_BLEN, PH_BDAT, PH_AID, PH_ALEN, PH_ADAT,
        PH_MASK, PH_META, PH_DONE, PH_ERR
    } t_phase;

    t_phase      r_phase,  n_phase;
    logic [2:0]  r_idx,    n_idx;
    logic [31:0] r_rem,    n_rem;
    logic [63:0] r_acc,    n_acc;
    logic [7:0]  r_flags,  n_flags;
    logic [7:0]  r_mask,   n_mask;
    logic [3:0]  r_err,    n_err;

    logic [63:0] acc_sh;
    logic [3:0]  idx_p1;
    logic [3:0]  need;
    logic        take_done;
    logic [31:0] rem_m1;
    t_phase      ph_after_after, ph_after_before, ph_after_opseq;
    logic [2:0]  meta_bit;
    logic [7:0]  mask_clr;
    logic        fld_hit;
    t_result     fld;
    t_result     end_res;
    logic [3:0]  end_status;

    // Byte accumulation into the little-endian value.
    assign acc_sh = r_acc | ({56'd0, i_in_byte} << {r_idx, 3'b000});
    assign idx_p1 = {1'b0, r_idx} + 4'd1;
    assign rem_m1 = r_rem - 32'd1;

    always_comb begin
        case (r_phase)
            PH_NLEN:           need = 4'd2;
            PH_OPSEQ, PH_META: need = 4'd8;
            default:           need = 4'd4;
        endcase
    end
    assign take_done = (idx_p1 >= need);

    // Optional sections that follow, as selected by the flags byte.
    assign ph_after_after  = r_flags[FLAG_META_BIT] ? PH_MASK : PH_DONE;
    assign ph_after_before = r_flags[FLAG_AFTER_BIT] ? PH_AID : ph_after_after;
    assign ph_after_opseq  = r_flags[FLAG_BEFORE_BIT] ? PH_BID : ph_after_before;

    // Lowest selected meta field; the top code covers an empty mask.
    always_comb begin
        meta_bit = 3'd6;
        for (int i = 6; i >= 0; i--) begin
            if (r_mask[i]) begin
                meta_bit = 3'(i);
            end
        end
    end
    assign mask_clr = r_mask & ~(8'd1 << meta_bit) & META_BITS;

    // Next state and the field result of this byte.
    always_comb begin
        n_phase = r_phase;
        n_idx   = r_idx;
        n_rem   = r_rem;
        n_acc   = r_acc;
        n_flags = r_flags;
        n_mask  = r_mask;
        n_err   = r_err;
        fld_hit = 1'b0;
        fld     = '0;

        if (r_phase == PH_NLEN || r_phase == PH_OPSEQ || r_phase == PH_BID ||
            r_phase == PH_BLEN || r_phase == PH_AID || r_phase == PH_ALEN ||
            r_phase == PH_META) begin
            if (take_done) begin
                n_acc = '0;
                n_idx = '0;
            end else begin
                n_acc = acc_sh;
                n_idx = idx_p1[2:0];
            end
        end

        case (r_phase)
            PH_MARK: begin
                if (i_in_byte == MARKER_V1) begin
                    n_phase = PH_NLEN;
                    n_idx   = '0;
                    n_acc   = '0;
                end else begin
                    n_err   = ST_BAD_MARKER;
                    n_phase = PH_ERR;
                end
            end
            PH_NLEN: begin
                if (take_done) begin
                    fld_hit    = 1'b1;
                    fld.kind   = KIND_NAME_LEN;
                    fld.value  = acc_sh;
                    n_rem      = {16'd0, acc_sh[15:0]};
                    n_phase    = (acc_sh[15:0] != 16'd0) ? PH_NAME : PH_FLAGS;
                end
            end
            PH_NAME: begin
                fld_hit   = 1'b1;
                fld.kind  = KIND_NAME_BYTE;
                fld.value = {56'd0, i_in_byte};
                n_rem     = rem_m1;
                if (rem_m1 == 32'd0) begin
                    n_phase = PH_FLAGS;
                end
            end
            PH_FLAGS: begin
                n_flags = i_in_byte;
                n_phase = PH_OPSEQ;
            end
            PH_OPSEQ: begin
                if (take_done) begin
                    fld_hit   = 1'b1;
                    fld.kind  = KIND_OP_SEQ;
                    fld.value = acc_sh;
                    n_phase   = ph_after_opseq;
                end
            end
            PH_BID, PH_AID: begin
                if (take_done) begin
                    fld_hit   = 1'b1;
                    fld.kind  = (r_phase == PH_BID) ? KIND_BEF_ID : KIND_AFT_ID;
                    fld.value = acc_sh;
                    n_phase   = (r_phase == PH_BID) ? PH_BLEN : PH_ALEN;
                end
            end
            PH_BLEN: begin
                if (take_done) begin
                    fld_hit   = 1'b1;
                    fld.kind  = KIND_BEF_LEN;
                    fld.value = acc_sh;
                    n_rem     = acc_sh[31:0];
                    n_phase   = (acc_sh[31:0] != 32'd0) ? PH_BDAT : ph_after_before;
                end
            end
            PH_BDAT: begin
                fld_hit   = 1'b1;
                fld.kind  = KIND_BEF_BYTE;
                fld.value = {56'd0, i_in_byte};
                n_rem     = rem_m1;
                if (rem_m1 == 32'd0) begin
                    n_phase = ph_after_before;
                end
            end
            PH_ALEN: begin
                if (take_done) begin
                    fld_hit   = 1'b1;
                    fld.kind  = KIND_AFT_LEN;
                    fld.value = acc_sh;
                    n_rem     = acc_sh[31:0];
                    n_phase   = (acc_sh[31:0] != 32'd0) ? PH_ADAT : ph_after_after;
                end
            end
            PH_ADAT: begin
                fld_hit   = 1'b1;
                fld.kind  = KIND_AFT_BYTE;
                fld.value = {56'd0, i_in_byte};
                n_rem     = rem_m1;
                if (rem_m1 == 32'd0) begin
                    n_phase = ph_after_after;
                end
            end
            PH_MASK: begin
                n_mask  = i_in_byte & META_BITS;
                n_phase = ((i_in_byte & META_BITS) != 8'd0) ? PH_META : PH_DONE;
            end
            PH_META: begin
                if (take_done) begin
                    fld_hit   = 1'b1;
                    fld.kind  = KIND_META_BASE + {2'd0, meta_bit};
                    fld.value = acc_sh;
                    n_mask    = mask_clr;
                    n_phase   = (mask_clr != 8'd0) ? PH_META : PH_DONE;
                end
            end
            default: begin
            end
        endcase
    end

    // Status carried by the end result, from the phase after this byte.
    always_comb begin
        case (n_phase)
            PH_MARK:           end_status = ST_BAD_MARKER;
            PH_NLEN:           end_status = ST_NAME_LEN_MISS;
            PH_NAME:           end_status = ST_NAME_TRUNC;
            PH_FLAGS:          end_status = ST_FLAGS_MISS;
            PH_OPSEQ, PH_META: end_status = ST_U64_TRUNC;
            PH_BID, PH_AID:    end_status = ST_ROW_ID_MISS;
            PH_BLEN, PH_ALEN:  end_status = ST_ROW_LEN_MISS;
            PH_BDAT, PH_ADAT:  end_status = ST_ROW_TRUNC;
            PH_MASK:           end_status = ST_MASK_MISS;
            PH_ERR:            end_status = n_err;
            default:           end_status = ST_OK;
        endcase
    end

    always_comb begin
        end_res        = '0;
        end_res.kind   = KIND_END;
        end_res.status = end_status;
        end_res.last   = 1'b1;
    end

    // The field result goes first; the end result follows it.
    assign o_res0    = fld_hit ? fld : end_res;
    assign o_res1    = end_res;
    assign o_res_cnt = {1'b0, fld_hit} + {1'b0, i_in_last};

    // State registers; the final byte returns everything to reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_MARK;
            r_idx   <= '0;
            r_rem   <= '0;
            r_acc   <= '0;
            r_flags <= '0;
            r_mask  <= '0;
            r_err   <= '0;
        end else if (i_step) begin
            if (i_in_last) begin
                r_phase <= PH_MARK;
                r_idx   <= '0;
                r_rem   <= '0;
                r_acc   <= '0;
                r_flags <= '0;
                r_mask  <= '0;
                r_err   <= '0;
            end else begin
                r_phase <= n_phase;
                r_idx   <= n_idx;
                r_rem   <= n_rem;
                r_acc   <= n_acc;
                r_flags <= n_flags;
                r_mask  <= n_mask;
                r_err   <= n_err;
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/wvpd_fifo.sv -----
// Result queue for the WAL v1 payload decoder: takes up to two results per cycle,
// hands out one per output transfer. Depends on wvpd_pkg.
`default_nettype none

module wvpd_fifo
    import wvpd_pkg::*;
#(
    parameter int unsigned P_DEPTH = FIFO_DEPTH_DEF
)
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [1:0] i_push_cnt,
    input  wire t_result    i_push0,
    input  wire t_result    i_push1,
    output logic            o_room2,
    output logic            o_valid,
    input  wire logic       i_stall,
    output t_result         o_data
);

    localparam int unsigned PW = $clog2(P_DEPTH);
    localparam int unsigned CW = $clog2(P_DEPTH + 1);
    localparam logic [CW-1:0] ROOM_MAX = CW'(P_DEPTH - 2);

    t_result         r_mem [P_DEPTH];
    logic [PW-1:0]   r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]   r_count;
    logic            pop;
    logic [PW-1:0]   wr_ptr_p1;

    assign o_valid   = (r_count != '0);
    assign o_data    = r_mem[r_rd_ptr];
    assign o_room2   = (r_count <= ROOM_MAX);
    assign pop       = o_valid && !i_stall;
    assign wr_ptr_p1 = r_wr_ptr + PW'(1);

    // Storage; the second result goes into the slot after the first.
    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[wr_ptr_p1] <= i_push1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + PW'(i_push_cnt);
            if (pop) begin
                r_rd_ptr <= r_rd_ptr + PW'(1);
            end
            r_count <= r_count + CW'(i_push_cnt) - CW'(pop);
        end
    end

endmodule

`default_nettype wire

// ----- tb/wvpd_decode_checker.sv -----
// Checker for the WAL v1 payload decoder: watches both channels and predicts every result.
// Depends on wvpd_pkg for the result type, tags and status codes.
`default_nettype none

module wvpd_decode_checker
    import wvpd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    input  wire logic        i_in_stall,
    input  wire logic [7:0]  i_in_byte,
    input  wire logic        i_in_last,
    input  wire logic        i_res_valid,
    input  wire logic        i_res_stall,
    input  wire logic [4:0]  i_field_kind,
    input  wire logic [63:0] i_field_value,
    input  wire logic [3:0]  i_status,
    input  wire logic        i_out_last,
    output int               o_errors,
    output int               o_pending,
    output int               o_bytes_used,
    output int               o_results,
    output int               o_ends
);
    timeunit 1ns;
    timeprecision 1ps;

    // Where the parser stands after the last byte it took.
    typedef enum logic [3:0] {
        AT_MARKER, AT_NAME_LEN, AT_NAME, AT_FLAGS, AT_OP_SEQ,
        AT_BEF_ID, AT_BEF_LEN, AT_BEF_DATA, AT_AFT_ID, AT_AFT_LEN, AT_AFT_DATA,
        AT_MASK, AT_META, AT_COMPLETE, AT_FAILED
    } t_parse_at;

    t_parse_at   parse_at;
    logic [2:0]  byte_pos;
    logic [31:0] run_left;
    logic [63:0] word_acc;
    logic [7:0]  flags_seen;
    logic [7:0]  meta_left;
    logic [3:0]  fail_code;

    t_result pending_fields[$];
    int      errors;
    int      bytes_used;
    int      results;
    int      ends;

    function automatic void clear_parser();
        parse_at   = AT_MARKER;
        byte_pos   = '0;
        run_left   = '0;
        word_acc   = '0;
        flags_seen = '0;
        meta_left  = '0;
        fail_code  = '0;
    endfunction

    function automatic void emit(input logic [4:0] kind, input logic [63:0] value,
                                 input logic [3:0] status, input logic closing);
        t_result r;
        r.kind   = kind;
        r.value  = value;
        r.status = status;
        r.last   = closing;
        pending_fields = {pending_fields, r};
    endfunction

    // Collects one little-endian byte; returns 1 once nbytes have been collected.
    function automatic logic gather(input logic [7:0] b, input int unsigned nbytes,
                                    output logic [63:0] word);
        word_acc = word_acc | (64'(b) << (8 * byte_pos));
        word = '0;
        if (int'(byte_pos) + 1 >= nbytes) begin
            word     = word_acc;
            word_acc = '0;
            byte_pos = '0;
            return 1'b1;
        end
        byte_pos = byte_pos + 3'd1;
        return 1'b0;
    endfunction

    // Sections that may follow the op sequence, chosen by the flags byte.
    function automatic t_parse_at past_after();
        return flags_seen[FLAG_META_BIT] ? AT_MASK : AT_COMPLETE;
    endfunction

    function automatic t_parse_at past_before();
        return flags_seen[FLAG_AFTER_BIT] ? AT_AFT_ID : past_after();
    endfunction

    function automatic t_parse_at past_op_seq();
        return flags_seen[FLAG_BEFORE_BIT] ? AT_BEF_ID : past_before();
    endfunction

    // Status of an end result, from the section that was being read.
    function automatic logic [3:0] end_status();
        case (parse_at)
            AT_FAILED:                return fail_code;
            AT_COMPLETE:              return ST_OK;
            AT_MARKER:                return ST_BAD_MARKER;
            AT_NAME_LEN:              return ST_NAME_LEN_MISS;
            AT_NAME:                  return ST_NAME_TRUNC;
            AT_FLAGS:                 return ST_FLAGS_MISS;
            AT_OP_SEQ, AT_META:       return ST_U64_TRUNC;
            AT_BEF_ID, AT_AFT_ID:     return ST_ROW_ID_MISS;
            AT_BEF_LEN, AT_AFT_LEN:   return ST_ROW_LEN_MISS;
            AT_BEF_DATA, AT_AFT_DATA: return ST_ROW_TRUNC;
            AT_MASK:                  return ST_MASK_MISS;
            default:                  return ST_OK;
        endcase
    endfunction

    // Advances the parser by one input byte and queues the results it causes.
    function automatic void decode_byte(input logic [7:0] b, input logic closing);
        logic [63:0] word;
        logic        done;
        int unsigned bit_no;

        // Bytes after a complete decode or an error only matter when they close the payload.
        if (closing || (parse_at != AT_COMPLETE && parse_at != AT_FAILED)) begin
            bytes_used++;
        end

        case (parse_at)
            AT_MARKER: begin
                if (b == MARKER_V1) begin
                    parse_at = AT_NAME_LEN;
                    byte_pos = '0;
                    word_acc = '0;
                end else begin
                    fail_code = ST_BAD_MARKER;
                    parse_at  = AT_FAILED;
                end
            end
            AT_NAME_LEN: begin
                done = gather(b, 2, word);
                if (done) begin
                    emit(KIND_NAME_LEN, word, ST_OK, 1'b0);
                    run_left = word[31:0];
                    parse_at = (run_left != 0) ? AT_NAME : AT_FLAGS;
                end
            end
            AT_NAME: begin
                emit(KIND_NAME_BYTE, 64'(b), ST_OK, 1'b0);
                run_left = run_left - 32'd1;
                if (run_left == 0) parse_at = AT_FLAGS;
            end
            AT_FLAGS: begin
                flags_seen = b;
                parse_at   = AT_OP_SEQ;
            end
            AT_OP_SEQ: begin
                done = gather(b, 8, word);
                if (done) begin
                    emit(KIND_OP_SEQ, word, ST_OK, 1'b0);
                    parse_at = past_op_seq();
                end
            end
            AT_BEF_ID: begin
                done = gather(b, 4, word);
                if (done) begin
                    emit(KIND_BEF_ID, word, ST_OK, 1'b0);
                    parse_at = AT_BEF_LEN;
                end
            end
            AT_BEF_LEN: begin
                done = gather(b, 4, word);
                if (done) begin
                    emit(KIND_BEF_LEN, word, ST_OK, 1'b0);
                    run_left = word[31:0];
                    parse_at = (run_left != 0) ? AT_BEF_DATA : past_before();
                end
            end
            AT_BEF_DATA: begin
                emit(KIND_BEF_BYTE, 64'(b), ST_OK, 1'b0);
                run_left = run_left - 32'd1;
                if (run_left == 0) parse_at = past_before();
            end
            AT_AFT_ID: begin
                done = gather(b, 4, word);
                if (done) begin
                    emit(KIND_AFT_ID, word, ST_OK, 1'b0);
                    parse_at = AT_AFT_LEN;
                end
            end
            AT_AFT_LEN: begin
                done = gather(b, 4, word);
                if (done) begin
                    emit(KIND_AFT_LEN, word, ST_OK, 1'b0);
                    run_left = word[31:0];
                    parse_at = (run_left != 0) ? AT_AFT_DATA : past_after();
                end
            end
            AT_AFT_DATA: begin
                emit(KIND_AFT_BYTE, 64'(b), ST_OK, 1'b0);
                run_left = run_left - 32'd1;
                if (run_left == 0) parse_at = past_after();
            end
            AT_MASK: begin
                meta_left = b & META_BITS;
                parse_at  = (meta_left != 0) ? AT_META : AT_COMPLETE;
            end
            AT_META: begin
                done = gather(b, 8, word);
                if (done) begin
                    // Meta fields arrive in mask bit order, lowest first.
                    for (bit_no = 0; bit_no < 7; bit_no++) begin
                        if (meta_left[bit_no]) break;
                    end
                    if (bit_no > 6) bit_no = 6;
                    emit(KIND_META_BASE + 5'(bit_no), word, ST_OK, 1'b0);
                    meta_left = meta_left & ~(8'd1 << bit_no) & META_BITS;
                    parse_at  = (meta_left != 0) ? AT_META : AT_COMPLETE;
                end
            end
            default: begin
            end
        endcase

        // The final byte closes the payload and starts the next one from scratch.
        if (closing) begin
            emit(KIND_END, 64'd0, end_status(), 1'b1);
            clear_parser();
        end
    endfunction

    // Compares one result transfer with the oldest prediction.
    function automatic void check_result();
        t_result want;
        results++;
        if (i_out_last) ends++;
        if (pending_fields.size() == 0) begin
            errors++;
            $display("%0t: result with nothing predicted: kind %0d value %h status %0d last %b",
                     $time, i_field_kind, i_field_value, i_status, i_out_last);
            return;
        end
        want = pending_fields.pop_front();
        if (i_field_kind !== want.kind) begin
            errors++;
            $display("%0t: field_kind mismatch, expected %0d, actual %0d",
                     $time, want.kind, i_field_kind);
        end
        if (i_field_value !== want.value) begin
            errors++;
            $display("%0t: field_value mismatch, expected %h, actual %h",
                     $time, want.value, i_field_value);
        end
        if (i_status !== want.status) begin
            errors++;
            $display("%0t: status mismatch, expected %0d, actual %0d",
                     $time, want.status, i_status);
        end
        if (i_out_last !== want.last) begin
            errors++;
            $display("%0t: out_last mismatch, expected %b, actual %b",
                     $time, want.last, i_out_last);
        end
    endfunction

    initial clear_parser();

    // Both channels are sampled at the rising edge; a transfer needs valid high and stall low.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_parser();
            pending_fields.delete();
        end else begin
            if (i_in_valid && !i_in_stall) decode_byte(i_in_byte, i_in_last);
            if (i_res_valid && !i_res_stall) check_result();
        end
        o_errors     <= errors;
        o_pending    <= pending_fields.size();
        o_bytes_used <= bytes_used;
        o_results    <= results;
        o_ends       <= ends;
    end

endmodule

`default_nettype wire

// ----- tb/wal_v1_payload_decoder_top_tb.sv -----
// Testbench top for the WAL v1 payload decoder: clock, reset, byte stream and verdict.
// Depends on wvpd_pkg, wal_v1_payload_decoder_top and wvpd_decode_checker.
`default_nettype none

module wal_v1_payload_decoder_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import wvpd_pkg::*;

    localparam int CLK_HALF  = 4;
    localparam int BYTE_GOAL = 1450;
    localparam int HOLD_LEN  = 400;
    localparam int HOLD_AT   = (2 * BYTE_GOAL) / 3 + 60;
    localparam int LIMIT     = 200000;

    logic        i_clk     = 1'b0;
    logic        i_rst_n   = 1'b0;
    logic        i_valid   = 1'b0;
    logic [7:0]  i_in_byte = 8'd0;
    logic        i_in_last = 1'b0;
    logic        i_stall   = 1'b0;
    logic        o_stall;
    logic        o_valid;
    logic [4:0]  o_field_kind;
    logic [63:0] o_field_value;
    logic [3:0]  o_status;
    logic        o_out_last;

    int errors;
    int pending;
    int bytes_used;
    int results;
    int ends;

    int         tx_idle_pct = 13;
    int         rx_idle_pct = 55;
    int         hold_left   = 0;
    logic       hold_taken  = 1'b0;
    int         cycles      = 0;
    int         payloads    = 0;
    logic [7:0] frame[$];

    wal_v1_payload_decoder_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_field_kind  (o_field_kind),
        .o_field_value (o_field_value),
        .o_status      (o_status),
        .o_out_last    (o_out_last)
    );

    wvpd_decode_checker u_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_in_byte     (i_in_byte),
        .i_in_last     (i_in_last),
        .i_res_valid   (o_valid),
        .i_res_stall   (i_stall),
        .i_field_kind  (o_field_kind),
        .i_field_value (o_field_value),
        .i_status      (o_status),
        .i_out_last    (o_out_last),
        .o_errors      (errors),
        .o_pending     (pending),
        .o_bytes_used  (bytes_used),
        .o_results     (results),
        .o_ends        (ends)
    );

    always #(CLK_HALF) i_clk = ~i_clk;

    // Run limit, far above the slowest correct run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT) begin
            $display("Timeout after %0d cycles with %0d results outstanding.", cycles, pending);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Result side: random stalls, plus one long hold-off that backs the decoder up.
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            i_stall   <= 1'b1;
        end else if (!hold_taken && bytes_used >= HOLD_AT) begin
            hold_left  <= HOLD_LEN;
            hold_taken <= 1'b1;
            i_stall    <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // Offers one byte, with random gaps ahead of it, and returns at its transfer.
    task automatic send_byte(input logic [7:0] b, input logic closing);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid   <= 1'b1;
        i_in_byte <= b;
        i_in_last <= closing;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    task automatic send_frame();
        for (int k = 0; k < frame.size(); k++) send_byte(frame[k], k == frame.size() - 1);
        payloads++;
    endtask

    function automatic void push_le(input logic [63:0] v, input int n);
        for (int k = 0; k < n; k++) frame = {frame, v[8 * k +: 8]};
    endfunction

    function automatic void push_image();
        int len;
        len = $urandom_range(6);
        push_le(64'($urandom), 4);
        push_le(64'(len), 4);
        repeat (len) frame = {frame, 8'($urandom_range(255))};
    endfunction

    // A well-formed payload with random content and mostly short runs.
    function automatic void build_record();
        int         name_len;
        logic [7:0] flags;
        logic [7:0] mask;
        name_len = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
        frame.delete();
        frame = {frame, MARKER_V1};
        push_le(64'(name_len), 2);
        repeat (name_len) frame = {frame, 8'($urandom_range(255))};
        flags = 8'($urandom_range(255));
        frame = {frame, flags};
        push_le({$urandom, $urandom}, 8);
        if (flags[FLAG_BEFORE_BIT]) push_image();
        if (flags[FLAG_AFTER_BIT]) push_image();
        if (flags[FLAG_META_BIT]) begin
            // Now and then a mask that selects nothing, with or without its unused bit.
            mask = ($urandom_range(4) == 0) ? 8'($urandom_range(1) << 7) : 8'($urandom_range(255));
            frame = {frame, mask};
            repeat ($countones(mask & META_BITS)) push_le({$urandom, $urandom}, 8);
        end
    endfunction

    // Mostly well-formed payloads; the rest cut short, badly marked or plain noise.
    function automatic void choose_payload();
        int         pick;
        int         cut;
        logic [7:0] b;
        pick = $urandom_range(99);
        if (pick < 70) begin
            build_record();
            if ($urandom_range(9) == 0) begin
                repeat ($urandom_range(3, 1)) frame = {frame, 8'($urandom_range(255))};
            end
        end else if (pick < 85) begin
            build_record();
            cut   = $urandom_range(frame.size() - 1, 1);
            frame = frame[0:cut - 1];
        end else if (pick < 93) begin
            b = 8'($urandom_range(255));
            if (b == MARKER_V1) b = ~b;
            frame.delete();
            frame = {frame, b};
            repeat ($urandom_range(5)) frame = {frame, 8'($urandom_range(255))};
        end else begin
            frame.delete();
            frame = {frame, MARKER_V1};
            repeat ($urandom_range(12, 1)) frame = {frame, 8'($urandom_range(255))};
        end
    endfunction

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a lone bad marker byte, and one followed by ignored bytes.
        frame = {8'h00};
        send_frame();
        frame = {8'h5A, 8'h11, 8'h22};
        send_frame();
        // A marker and nothing more: the name length is missing.
        frame = {MARKER_V1};
        send_frame();
        // Empty name, only unused flag bits, all-ones op sequence, then a trailing byte.
        frame = {MARKER_V1, 8'h00, 8'h00, 8'h7C};
        push_le(64'hFFFF_FFFF_FFFF_FFFF, 8);
        frame = {frame, 8'hAA};
        send_frame();
        // A name length of one with the name byte missing.
        frame = {MARKER_V1, 8'h01, 8'h00};
        send_frame();

        // Random payloads through three idle settings; the last runs without gaps.
        while (bytes_used < BYTE_GOAL) begin
            if (bytes_used >= (2 * BYTE_GOAL) / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end else if (bytes_used >= BYTE_GOAL / 3) begin
                tx_idle_pct = 55;
                rx_idle_pct = 13;
            end
            choose_payload();
            send_frame();
        end
        i_valid <= 1'b0;

        // Drain what is still predicted, then allow a few cycles for strays.
        do @(posedge i_clk); while (pending != 0);
        repeat (16) @(posedge i_clk);

        $display("Covered %0d payloads and %0d parsed bytes; %0d results checked, %0d of them ends.",
                 payloads, bytes_used, results, ends);
        $display("Idle mixes 13/55 and 55/13 percent, a gapless stretch, one %0d-cycle result hold.",
                 HOLD_LEN);
        if (errors == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/wvpd_pkg.sv
rtl/wvpd_decode.sv
rtl/wvpd_fifo.sv
rtl/wal_v1_payload_decoder_top.sv
tb/wvpd_decode_checker.sv
tb/wal_v1_payload_decoder_top_tb.sv
